### hw/rtl/dual_axis_trapezoid_profile_unit_defines.svh
// assertion macros for the profile unit checker
`ifndef DUAL_AXIS_TRAPEZOID_PROFILE_UNIT_DEFINES_SVH
`define DUAL_AXIS_TRAPEZOID_PROFILE_UNIT_DEFINES_SVH

`define DATP_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define DATP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/datp_pkg.sv
package datp_pkg;

    localparam int FRAC_BITS_DEF = 20;

    localparam logic [2:0] REG_P_VMAX = 3'd0;
    localparam logic [2:0] REG_P_AMAX = 3'd1;
    localparam logic [2:0] REG_R_VMAX = 3'd2;
    localparam logic [2:0] REG_R_AMAX = 3'd3;
    localparam logic [2:0] REG_P_REV  = 3'd4;
    localparam logic [2:0] REG_R_REV  = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture beat and config, resync positions
        logic axis_sel; // 0 pitch, 1 roll
        logic prep;     // compute err, max_dv, stop_v
        logic sq_mul;   // form 2*acc*|err|
        logic sq_start;
        logic upd;      // velocity update
        logic pmul;     // vel*dt
        logic wb;       // position writeback
    } datp_cmd_t;

    typedef struct packed {
        logic sq_done;
    } datp_sts_t;

endpackage

### hw/rtl/datp_isqrt.sv
// bit-pair restoring square root, one result bit per cycle
module datp_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;
    assign done  = busy_reg && (bit_reg == 64'd0);
    assign root  = r_reg[31:0];

    always_comb begin
        v_next = v_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        if (start) begin
            v_next = radicand;
            r_next = 64'd0;
            bit_next = 64'd1 << 62;
            busy_next = 1'b1;
        end else if (busy_reg && bit_reg != 64'd0) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        v_reg <= v_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
    end
endmodule

### hw/rtl/datp_datapath.sv
module datp_datapath #(
    parameter int FRAC_BITS = datp_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  datp_pkg::datp_cmd_t cmd,
    output datp_pkg::datp_sts_t sts,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [29:0]         cfg_data,
    input  logic signed [31:0]  pitch_target,
    input  logic signed [31:0]  roll_target,
    input  logic signed [31:0]  pitch_measured,
    input  logic signed [31:0]  roll_measured,
    input  logic [15:0]         step_time,
    input  logic                resync,
    output logic signed [31:0]  pitch_position,
    output logic signed [27:0]  pitch_velocity,
    output logic signed [31:0]  roll_position,
    output logic signed [27:0]  roll_velocity
);
    localparam longint ONE_Q     = 64'sd1 <<< FRAC_BITS;
    localparam longint POS_EPS   = (2 * ONE_Q + 500) / 1000;
    localparam longint VEL_EPS   = (20 * ONE_Q + 500) / 1000;
    localparam longint LIM_FLOOR = (ONE_Q + 50) / 100;
    localparam longint DT_MIN    = (5 * ONE_Q + 5000) / 10000;
    localparam longint DT_MAX    = (5 * ONE_Q + 50) / 100;
    localparam longint HALF_Q    = ONE_Q >>> 1;

    logic [26:0] p_vmax_reg, r_vmax_reg;
    logic [29:0] p_amax_reg, r_amax_reg;
    logic        p_rev_reg, r_rev_reg;
    logic        synced_reg;

    logic signed [33:0] pos_reg [2];
    logic signed [33:0] vel_reg [2];
    logic signed [33:0] tgt_reg [2];
    logic signed [33:0] vmax_reg [2];
    logic signed [33:0] amax_reg [2];
    logic signed [33:0] dt_reg;

    logic signed [33:0] err_reg, aerr_reg, maxdv_reg, stopv_reg;
    logic [63:0]        rad_reg;
    logic signed [49:0] prod_reg;
    logic               snap_reg;

    logic               sq_done;
    logic [31:0]        sq_root;

    logic               a;
    assign a = cmd.axis_sel;

    datp_isqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.sq_start),
        .radicand(rad_reg), .done(sq_done), .root(sq_root)
    );
    assign sts.sq_done = sq_done;

    function automatic logic signed [33:0] fb(input logic signed [31:0] m, input logic rev);
        logic signed [33:0] x;
        x = 34'(m);
        if (rev) begin
            x = -x;
            if (x > 34'sd2147483647) x = 34'sd2147483647;
        end
        return x;
    endfunction

    function automatic logic signed [33:0] flim(input logic [29:0] v);
        return (34'(v) < 34'(LIM_FLOOR)) ? 34'(LIM_FLOOR) : $signed({4'd0, v});
    endfunction

    function automatic logic signed [33:0] abs34(input logic signed [33:0] v);
        return v < 0 ? -v : v;
    endfunction

    logic signed [33:0] dt_c;
    logic signed [63:0] adt;
    logic signed [33:0] brake, desired, dv, vn, mdv;
    logic signed [49:0] aprod, mag;
    logic signed [33:0] npos;

    always_comb begin
        dt_c = $signed({18'd0, step_time});
        if (dt_c < 34'(DT_MIN)) dt_c = 34'(DT_MIN);
        if (dt_c > 34'(DT_MAX)) dt_c = 34'(DT_MAX);
        adt = 64'(amax_reg[a]) * 64'(dt_reg);
        brake = $signed({2'd0, sq_root});
        desired = brake < vmax_reg[a] ? brake : vmax_reg[a];
        if (err_reg < 0) desired = -desired;
        if (brake < stopv_reg) desired = '0;
        mdv = maxdv_reg;
        dv = desired - vel_reg[a];
        if (dv < -mdv) dv = -mdv;
        if (dv > mdv) dv = mdv;
        vn = vel_reg[a] + dv;
        if (vn < -vmax_reg[a]) vn = -vmax_reg[a];
        if (vn > vmax_reg[a]) vn = vmax_reg[a];
        aprod = prod_reg < 0 ? -prod_reg : prod_reg;
        mag = (aprod + 50'(HALF_Q)) >>> FRAC_BITS;
        npos = 34'(pos_reg[a] + (prod_reg < 0 ? -mag : mag));
        if (npos > 34'sd2147483647) npos = 34'sd2147483647;
        if (npos < -34'sd2147483648) npos = -34'sd2147483648;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vmax_reg <= 27'(LIM_FLOOR);
            r_vmax_reg <= 27'(LIM_FLOOR);
            p_amax_reg <= 30'(LIM_FLOOR);
            r_amax_reg <= 30'(LIM_FLOOR);
            p_rev_reg <= 1'b0;
            r_rev_reg <= 1'b0;
            synced_reg <= 1'b0;
            pos_reg[0] <= '0; pos_reg[1] <= '0;
            vel_reg[0] <= '0; vel_reg[1] <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    datp_pkg::REG_P_VMAX: p_vmax_reg <= cfg_data[26:0];
                    datp_pkg::REG_P_AMAX: p_amax_reg <= cfg_data;
                    datp_pkg::REG_R_VMAX: r_vmax_reg <= cfg_data[26:0];
                    datp_pkg::REG_R_AMAX: r_amax_reg <= cfg_data;
                    datp_pkg::REG_P_REV:  p_rev_reg <= cfg_data[0];
                    datp_pkg::REG_R_REV:  r_rev_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                tgt_reg[0] <= 34'(pitch_target);
                tgt_reg[1] <= 34'(roll_target);
                vmax_reg[0] <= flim({3'd0, p_vmax_reg});
                vmax_reg[1] <= flim({3'd0, r_vmax_reg});
                amax_reg[0] <= flim(p_amax_reg);
                amax_reg[1] <= flim(r_amax_reg);
                dt_reg <= dt_c;
                if (!synced_reg || resync) begin
                    pos_reg[0] <= fb(pitch_measured, p_rev_reg);
                    pos_reg[1] <= fb(roll_measured, r_rev_reg);
                    vel_reg[0] <= '0;
                    vel_reg[1] <= '0;
                end
                synced_reg <= 1'b1;
            end
            if (cmd.upd) begin
                if (snap_reg) begin
                    vel_reg[a] <= '0;
                    pos_reg[a] <= tgt_reg[a];
                end else begin
                    vel_reg[a] <= vn;
                end
            end
            if (cmd.wb) begin
                // second snap test on the new velocity
                if (aerr_reg <= 34'(POS_EPS) && abs34(vel_reg[a]) <= stopv_reg) begin
                    vel_reg[a] <= '0;
                    pos_reg[a] <= tgt_reg[a];
                end else if (!snap_reg) begin
                    pos_reg[a] <= npos;
                end
            end
        end
        if (cmd.prep) begin
            err_reg <= tgt_reg[a] - pos_reg[a];
            aerr_reg <= abs34(tgt_reg[a] - pos_reg[a]);
            maxdv_reg <= 34'(adt >>> FRAC_BITS);
            stopv_reg <= (34'(adt >>> FRAC_BITS) > 34'(VEL_EPS))
                         ? 34'(adt >>> FRAC_BITS) : 34'(VEL_EPS);
        end
        if (cmd.sq_mul) begin
            rad_reg <= {amax_reg[a][31:0], 1'b0} * 64'(aerr_reg[32:0]);
            snap_reg <= aerr_reg <= 34'(POS_EPS) && abs34(vel_reg[a]) <= stopv_reg;
        end
        if (cmd.pmul) begin
            prod_reg <= 50'(vel_reg[a]) * 50'(dt_reg);
        end
    end

    assign pitch_position = pos_reg[0][31:0];
    assign pitch_velocity = vel_reg[0][27:0];
    assign roll_position  = pos_reg[1][31:0];
    assign roll_velocity  = vel_reg[1][27:0];
endmodule

### hw/rtl/datp_ctrl.sv
module datp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output datp_pkg::datp_cmd_t cmd,
    input  datp_pkg::datp_sts_t sts
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_SQM  = 3'd2;
    localparam logic [2:0] ST_SQS  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_PMUL = 3'd5;
    localparam logic [2:0] ST_WB   = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       axis_reg, axis_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        axis_next = axis_reg;
        cmd = '0;
        cmd.axis_sel = axis_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.load = 1'b1;
                axis_next = 1'b0;
                state_next = ST_PREP;
            end
            ST_PREP: begin cmd.prep = 1'b1; state_next = ST_SQM; end
            ST_SQM:  begin cmd.sq_mul = 1'b1; state_next = ST_SQS; end
            ST_SQS:  begin cmd.sq_start = 1'b1; state_next = ST_WAIT; end
            ST_WAIT: if (sts.sq_done) begin
                cmd.upd = 1'b1;
                state_next = ST_PMUL;
            end
            ST_PMUL: begin cmd.pmul = 1'b1; state_next = ST_WB; end
            ST_WB: begin
                cmd.wb = 1'b1;
                if (axis_reg) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg <= axis_next;
        end
    end
endmodule

### hw/rtl/dual_axis_trapezoid_profile_unit.sv
// channel  | handshake          | payload
// s_ input | s_valid / s_ready  | targets, measured angles, step_time, resync
// m_ out   | m_valid / m_ready  | pitch/roll position and velocity
// from one taken beat to the next, each axis in turn runs prep, multiply, a
// 32-step square root, velocity update and position multiply on shared units,
// then the result is offered; one beat in flight
// synchronous active-low reset clears limits to 0.01, flags and profile state
// a stalled result holds and no new beat is taken until it leaves
module dual_axis_trapezoid_profile_unit #(
    parameter int FRAC_BITS = datp_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [29:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pitch_target,
    input  logic signed [31:0] s_roll_target,
    input  logic signed [31:0] s_pitch_measured,
    input  logic signed [31:0] s_roll_measured,
    input  logic [15:0]        s_step_time,
    input  logic               s_resync,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pitch_position,
    output logic signed [27:0] m_pitch_velocity,
    output logic signed [31:0] m_roll_position,
    output logic signed [27:0] m_roll_velocity
);
    datp_pkg::datp_cmd_t cmd;
    datp_pkg::datp_sts_t sts;

    datp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    datp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .pitch_target(s_pitch_target), .roll_target(s_roll_target),
        .pitch_measured(s_pitch_measured), .roll_measured(s_roll_measured),
        .step_time(s_step_time), .resync(s_resync),
        .pitch_position(m_pitch_position), .pitch_velocity(m_pitch_velocity),
        .roll_position(m_roll_position), .roll_velocity(m_roll_velocity)
    );
endmodule

### hw/rtl/datp_checker.sv
`include "dual_axis_trapezoid_profile_unit_defines.svh"

module datp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_pitch_position,
    input logic [31:0] m_roll_position
);
    // one beat in flight: no input taken while a result is pending
    `DATP_ASSERT_IMPL(a_excl, aclk, aresetn, !(s_ready && m_valid), "ready while result pending")
    // a taken input does not yield a result on the next edge
    `DATP_ASSERT_IMPL(a_lat, aclk, aresetn, (s_valid && s_ready) |=> !m_valid, "result too early")
    // stalled result holds its positions
    `DATP_ASSERT_IMPL(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_pitch_position) && $stable(m_roll_position)), "result changed under stall")
    // out of reset nothing is offered
    `DATP_ASSERT_RST(a_rst, aclk, !aresetn |=> !m_valid, "result after reset")
endmodule

bind dual_axis_trapezoid_profile_unit datp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_pitch_position(m_pitch_position), .m_roll_position(m_roll_position)
);
